[hw/rtl/assert_macros.svh]
// Assertion helpers for the LSU checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is held off while reset is asserted.
`define LSU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Same, for a property that must also hold while reset is asserted.
`define LSU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[hw/rtl/lsu_pkg.sv]
`timescale 1ns / 1ps

package lsu_pkg;

    localparam int MAX_ELEMENTS = 16;
    localparam int DATA_W       = 32;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CMP   = 6'b000010,
        S_PLACE = 6'b000100,
        S_EREAD = 6'b001000,
        S_EWAIT = 6'b010000,
        S_EOUT  = 6'b100000
    } t_state;

endpackage

[hw/rtl/lsu_ram.sv]
`timescale 1ns / 1ps

module lsu_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[hw/rtl/ascending_list_sorter_unit.sv]
`timescale 1ns / 1ps

// Collects a list of signed 32-bit values and returns it in ascending order.
// Each accepted value is placed by insertion into a single-port-write,
// single-port-read memory: the entries above it are read one per cycle and
// moved up one place until the slot is found, then the value is written
// there. Values beyond MAX_ELEMENTS are dropped. When the value with the last
// mark is taken, the list is sent out; each result is read from memory,
// captured and then transferred, and the next read starts only once the
// output takes the result. o_stall is high for the whole time the block
// works on an item or sends a list.
module ascending_list_sorter_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [lsu_pkg::DATA_W-1:0] i_value,
    input  logic                        i_last,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [lsu_pkg::DATA_W-1:0] o_sorted_value,
    output logic                        o_last_out
);

    import lsu_pkg::*;

    t_state                    r_state, n_state;
    logic signed [DATA_W-1:0]  r_value, n_value;
    logic                      r_last, n_last;
    logic [CNT_W-1:0]          r_pos, n_pos;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [CNT_W-1:0]          r_k, n_k;
    logic signed [DATA_W-1:0]  r_out, n_out;
    logic                      r_out_last, n_out_last;

    logic                      we;
    logic [IDX_W-1:0]          waddr;
    logic [DATA_W-1:0]         wdata;
    logic [IDX_W-1:0]          raddr;
    logic [DATA_W-1:0]         rdata;
    logic [CNT_W-1:0]          tmp;

    lsu_ram #(
        .DEPTH (MAX_ELEMENTS),
        .WIDTH (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_value    = r_value;
        n_last     = r_last;
        n_pos      = r_pos;
        n_count    = r_count;
        n_k        = r_k;
        n_out      = r_out;
        n_out_last = r_out_last;
        we         = 1'b0;
        waddr      = r_pos[IDX_W-1:0];
        wdata      = r_value;
        raddr      = r_k[IDX_W-1:0];
        tmp        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_value = i_value;
                    n_last  = i_last;
                    n_pos   = r_count;
                    n_k     = '0;
                    if (r_count == CNT_W'(MAX_ELEMENTS)) begin
                        // Store full: the value is dropped, a last mark still ends the list.
                        n_state = i_last ? S_EREAD : S_IDLE;
                    end else if (r_count == '0) begin
                        n_state = S_PLACE;
                    end else begin
                        tmp     = r_count - CNT_W'(1);
                        raddr   = tmp[IDX_W-1:0];
                        n_state = S_CMP;
                    end
                end
            end
            S_CMP: begin
                we    = 1'b1;
                waddr = r_pos[IDX_W-1:0];
                if (r_value < $signed(rdata)) begin
                    wdata = rdata;
                    n_pos = r_pos - CNT_W'(1);
                    if (r_pos == CNT_W'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        tmp   = r_pos - CNT_W'(2);
                        raddr = tmp[IDX_W-1:0];
                    end
                end else begin
                    wdata   = r_value;
                    n_count = r_count + CNT_W'(1);
                    n_state = r_last ? S_EREAD : S_IDLE;
                end
            end
            S_PLACE: begin
                we      = 1'b1;
                waddr   = r_pos[IDX_W-1:0];
                wdata   = r_value;
                n_count = r_count + CNT_W'(1);
                n_state = r_last ? S_EREAD : S_IDLE;
            end
            S_EREAD: begin
                raddr   = r_k[IDX_W-1:0];
                n_state = S_EWAIT;
            end
            S_EWAIT: begin
                n_out      = rdata;
                n_out_last = (r_k == r_count - CNT_W'(1));
                n_state    = S_EOUT;
            end
            S_EOUT: begin
                if (!i_stall) begin
                    if (r_out_last) begin
                        n_count = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + CNT_W'(1);
                        n_state = S_EREAD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_value    <= n_value;
        r_last     <= n_last;
        r_pos      <= n_pos;
        r_k        <= n_k;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = (r_state == S_EOUT);
    assign o_sorted_value = r_out;
    assign o_last_out     = r_out_last;

endmodule

[hw/rtl/lsu_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lsu_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        i_last,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [lsu_pkg::DATA_W-1:0]  o_sorted_value,
    input logic                        o_last_out
);

    import lsu_pkg::*;

    // A stalled result holds its value.
    `LSU_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_sorted_value) && $stable(o_last_out), "stalled result changed")

    // While results are sent, no input transfer is taken.
    `LSU_ASSERT(a_busy_out, o_valid |-> o_stall, "input open while sending results")

    // An item without the last mark causes no result in the next cycle.
    `LSU_ASSERT(a_no_early, i_valid && !o_stall && !i_last |=> !o_valid, "result without last mark")

    // After the final result transfer the output goes quiet.
    `LSU_ASSERT(a_end_list, o_valid && !i_stall && o_last_out |=> !o_valid, "result after end of list")

endmodule

bind ascending_list_sorter_unit lsu_checker u_lsu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_last         (i_last),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_sorted_value (o_sorted_value),
    .o_last_out     (o_last_out)
);

[bench/ascending_list_sorter_unit_checker.sv]
`timescale 1ns / 1ps

module ascending_list_sorter_unit_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic                               i_in_stall,
    input  logic signed [lsu_pkg::DATA_W-1:0]  i_value,
    input  logic                               i_last,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic signed [lsu_pkg::DATA_W-1:0]  i_sorted_value,
    input  logic                               i_last_out,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_lists_done,
    output int                                 o_results_seen
);
    import lsu_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_sorted_entry;

    logic signed [DATA_W-1:0] held_list[$];
    t_sorted_entry            sorted_queue[$];

    // Insertion keeps the held list ascending; a full list drops new values.
    task automatic predict_sorted(input logic signed [DATA_W-1:0] v, input logic lst);
        int pos;
        t_sorted_entry ent;
        if (held_list.size() < MAX_ELEMENTS) begin
            pos = held_list.size();
            while (pos > 0 && v < held_list[pos-1]) pos--;
            held_list.insert(pos, v);
        end
        if (lst) begin
            foreach (held_list[k]) begin
                ent.value = held_list[k];
                ent.last  = (k == held_list.size() - 1);
                sorted_queue.push_back(ent);
            end
            held_list.delete();
            o_lists_done++;
        end
    endtask

    always @(posedge i_clk) begin
        t_sorted_entry exp_ent;
        if (i_rst_n) begin
            if (i_valid && !i_in_stall) predict_sorted(i_value, i_last);
            if (i_out_valid && !i_out_stall) begin
                o_results_seen++;
                if (sorted_queue.size() == 0) begin
                    $error("result transfer with nothing expected: value %0d", i_sorted_value);
                    o_fail_count++;
                end else begin
                    exp_ent = sorted_queue.pop_front();
                    if (i_sorted_value !== exp_ent.value) begin
                        $error("sorted_value: expected %0d, got %0d", exp_ent.value,
                               i_sorted_value);
                        o_fail_count++;
                    end
                    if (i_last_out !== exp_ent.last) begin
                        $error("last_out: expected %0b, got %0b", exp_ent.last, i_last_out);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = sorted_queue.size();
    end
endmodule

[bench/ascending_list_sorter_unit_test.sv]
`timescale 1ns / 1ps

module ascending_list_sorter_unit_test;
    import lsu_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic signed [DATA_W-1:0]  i_value;
    logic                      i_last;
    logic                      o_valid;
    logic                      i_stall;
    logic signed [DATA_W-1:0]  o_sorted_value;
    logic                      o_last_out;

    int fail_count, pending, lists_done, results_seen;
    int send_idle_pct, recv_stall_pct, hold_off_cycles, cycle_count;
    int hold_count;
    int items_sent;

    ascending_list_sorter_unit u_top (.*);

    ascending_list_sorter_unit_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_in_stall(o_stall), .i_value(i_value), .i_last(i_last),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_sorted_value(o_sorted_value), .i_last_out(o_last_out),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_lists_done(lists_done), .o_results_seen(results_seen)
    );

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // Receiver: random stalls, plus a long hold-off when asked.
    always @(negedge i_clk) begin
        if (hold_count < hold_off_cycles) begin
            i_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL ascending_list_sorter_unit");
            $finish;
        end
    end

    task automatic send_item(input logic signed [DATA_W-1:0] v, input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        i_last  <= lst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $urandom_range(7) - 4;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_list(input int len);
        for (int k = 0; k < len; k++) send_item(pick_value(), k == len - 1);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    initial begin
        int len;
        i_valid = 1'b0; i_value = '0; i_last = 1'b0; i_rst_n = 1'b0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_off_cycles = 0;
        items_sent = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: single value, extremes, duplicates, reverse order, overflow.
        send_item(32'sh8000_0000, 1'b1);
        send_item(32'sh7fff_ffff, 1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sh0000_0000, 1'b0);
        send_item(-32'sd1, 1'b1);
        send_item(32'sd5, 1'b0);
        send_item(32'sd5, 1'b0);
        send_item(32'sd5, 1'b1);
        for (int k = 0; k < MAX_ELEMENTS + 1; k++)
            send_item(100 - k, k == MAX_ELEMENTS);
        drain_results();

        // Full list plus an overflowing value that carries the last mark.
        for (int k = 0; k < MAX_ELEMENTS + 1; k++)
            send_item($urandom, k == MAX_ELEMENTS);
        drain_results();

        // Hold the output off long enough that the input must stall.
        hold_off_cycles = 300;
        for (int k = 0; k < 8; k++) send_list(3);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1 || phase == 3) ? 76 : (phase == 3 ? 10 : 0);
            recv_stall_pct = (phase == 2 || phase == 3) ? 76 : 0;
            if (phase == 3) begin
                send_idle_pct  = 10;
                recv_stall_pct = 10;
            end
            for (int n = 0; n < 15; n++) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(MAX_ELEMENTS, MAX_ELEMENTS + 3)
                                                : $urandom_range(1, 6);
                send_list(len);
            end
            drain_results();
        end

        $display("Sent %0d values in %0d lists; %0d sorted results checked.",
                 items_sent, lists_done, results_seen);
        if (fail_count == 0) begin
            $display("PASS ascending_list_sorter_unit");
        end else begin
            $display("FAIL ascending_list_sorter_unit");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/lsu_pkg.sv
hw/rtl/lsu_ram.sv
hw/rtl/ascending_list_sorter_unit.sv
hw/rtl/lsu_checker.sv
bench/ascending_list_sorter_unit_checker.sv
bench/ascending_list_sorter_unit_test.sv
